// ===== src/extended_tofts_tissue_conc_defines.svh =====
// Assertion macros for the extended Tofts tissue concentration block.
`ifndef EXTENDED_TOFTS_TISSUE_CONC_DEFINES_SVH
`define EXTENDED_TOFTS_TISSUE_CONC_DEFINES_SVH

// Antecedent in this cycle implies consequent in the next cycle.
`define ETS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle property");

// Antecedent implies consequent in the same cycle.
`define ETS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle property");

`endif

// ===== src/ets_pkg.sv =====
// Shared constants and tables for the extended Tofts tissue concentration block.
package ets_pkg;

    localparam int AIF_W   = 24;
    localparam int TIME_W  = 24;
    localparam int KTR_W   = 20;
    localparam int FRAC_W  = 17;
    localparam int OPA_W   = 40;
    localparam int OPB_W   = 24;
    localparam int PROD_W  = 64;
    localparam int CFG_IDX_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KTRANS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VP     = 2'd2;

    localparam logic [KTR_W-1:0]  KTRANS_RST = 20'd13107;
    localparam logic [FRAC_W-1:0] VE_RST     = 17'd13107;
    localparam logic [FRAC_W-1:0] VP_RST     = 17'd13107;

    // log2(e) in Q.16
    localparam logic [OPB_W-1:0] LOG2E_Q16 = 24'd94548;

    // round(65536 * 2^(-k/16)), k = 0..16
    function automatic logic [16:0] pow2_neg(input logic [4:0] k);
        logic [16:0] v;
        unique case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

// ===== src/extended_tofts_tissue_conc.sv =====
// Extended Tofts tissue concentration with a recursive trapezoid integral.
// A series start with nonzero ve and ktrans first runs the restoring divider for kep.
// All products share one shift-add multiplier: 8 products per series sample with nonzero
// ve and ktrans, one product (vp * Ca) at a series start or when ve or ktrans is zero.
// A new item is taken only once the last one is through; s_tready is high only while the sequencer idles.
// Reset (aresetn low, synchronous): registers to 13107, series state to zero.
module extended_tofts_tissue_conc (
    input  logic        aclk,
    input  logic        aresetn,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [23:0] aif_conc, [47:24] sample_time
    input  logic        s_tuser,   // [0] first_sample
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [23:0] tissue_conc
    output logic        m_tuser    // [0] saturated
);
    import ets_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_STEP, S_OUT} state_t;
    typedef enum logic [2:0] {
        PH_VPCA, PH_X, PH_Y, PH_INTERP, PH_PE, PH_A, PH_IE, PH_KI
    } phase_t;

    state_t state_reg;
    phase_t phase_reg;

    logic [KTR_W-1:0]  ktrans_reg;
    logic [FRAC_W-1:0] ve_reg;
    logic [FRAC_W-1:0] vp_reg;

    logic [AIF_W-1:0]  prev_aif_reg;
    logic [TIME_W-1:0] prev_time_reg;
    logic [39:0]       integ_reg;
    logic [31:0]       kep_reg;

    logic [AIF_W-1:0]  ca_reg;
    logic [TIME_W-1:0] t_reg;
    logic              first_reg;
    logic [TIME_W-1:0] dt_reg;
    logic [40:0]       vpca_reg;
    logic [4:0]        n_reg;
    logic [3:0]        idx_reg;
    logic              ezero_reg;
    logic [16:0]       e_reg;
    logic [33:0]       a_reg;
    logic [PROD_W-1:0] acc_reg;
    logic              sat_reg;

    // shared multiplier
    logic [PROD_W-1:0] ma_reg;
    logic [OPB_W-1:0]  mb_reg;
    logic [PROD_W-1:0] mp_reg;
    logic [4:0]        mcnt_reg;

    // restoring divider
    logic [16:0]       drem_reg;
    logic [35:0]       dq_reg;
    logic [5:0]        dcnt_reg;

    logic              out_valid_reg;
    logic [23:0]       out_data_reg;
    logic              out_sat_reg;
    logic              out_wait;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_sat_reg;
    assign out_wait  = (state_reg == S_OUT) && out_valid_reg && !m_tready;

    // input decode
    logic [AIF_W-1:0]  in_ca;
    logic [TIME_W-1:0] in_t;
    logic [TIME_W-1:0] in_dt;
    logic              params_zero;
    assign in_ca = s_tdata[23:0];
    assign in_t  = s_tdata[47:24];
    assign in_dt = (in_t > prev_time_reg) ? (in_t - prev_time_reg) : '0;
    assign params_zero = (ve_reg == '0) || (ktrans_reg == '0);

    // divider step
    logic [17:0] d_trial;
    logic        d_ge;
    logic [17:0] d_sub;
    logic [35:0] d_quot;
    logic [31:0] kep_sat;
    assign d_trial = {1'b0, drem_reg} << 1 | {17'b0, dq_reg[35]};
    assign d_ge    = d_trial >= {1'b0, ve_reg};
    assign d_sub   = d_ge ? (d_trial - {1'b0, ve_reg}) : d_trial;
    assign d_quot  = {dq_reg[34:0], d_ge};
    assign kep_sat = (d_quot[35:32] != '0) ? 32'hFFFF_FFFF : d_quot[31:0];

    // decay factor from the interpolation product
    logic [16:0] tab_hi;
    logic [16:0] tab_lo;
    logic [24:0] interp_sum;
    logic [16:0] v_val;
    logic [17:0] v_rnd;
    logic [16:0] e_calc;
    assign tab_hi     = pow2_neg({1'b0, idx_reg});
    assign interp_sum = {1'b0, mp_reg[23:0]} + 25'd2048;
    assign v_val      = tab_hi - {4'b0, interp_sum[24:12]};
    assign v_rnd      = ({1'b0, v_val} + (18'd1 << (n_reg - 5'd1))) >> n_reg;

    always_comb begin
        priority if (ezero_reg) begin
            e_calc = '0;
        end else if (n_reg == '0) begin
            e_calc = v_val;
        end else begin
            e_calc = v_rnd[16:0];
        end
    end

    // products brought back to Q.16
    logic [PROD_W:0] rnd16;
    logic [25:0]     sum_calc;
    logic [41:0]     integ_calc;
    logic            integ_ovf;
    logic [39:0]     integ_clip;
    logic [PROD_W:0] res_sum;
    logic            res_ovf;
    assign rnd16      = {1'b0, mp_reg} + 65'd32768;
    assign sum_calc   = {2'b0, ca_reg} + rnd16[41:16];
    assign integ_calc = rnd16[57:16] + {8'b0, a_reg};
    assign integ_ovf  = integ_calc[41:40] != '0;
    assign integ_clip = integ_ovf ? {40{1'b1}} : integ_calc[39:0];
    assign res_sum    = {1'b0, acc_reg} + 65'd32768;
    assign res_ovf    = res_sum[64:40] != '0;

    // operands of the product that follows each phase
    logic [OPA_W-1:0] step_a;
    logic [OPB_W-1:0] step_b;
    phase_t           step_phase;
    logic [3:0]       y_idx;
    assign y_idx  = mp_reg[31:28];
    assign tab_lo = pow2_neg({1'b0, y_idx} + 5'd1);

    always_comb begin
        unique case (phase_reg)
            PH_VPCA: begin
                step_a = {8'b0, kep_reg};
                step_b = dt_reg;
                step_phase = PH_X;
            end
            PH_X: begin
                step_a = mp_reg[55:16];
                step_b = LOG2E_Q16;
                step_phase = PH_Y;
            end
            PH_Y: begin
                step_a = {23'b0, pow2_neg({1'b0, y_idx}) - tab_lo};
                step_b = {12'b0, mp_reg[27:16]};
                step_phase = PH_INTERP;
            end
            PH_INTERP: begin
                step_a = {16'b0, prev_aif_reg};
                step_b = {7'b0, e_calc};
                step_phase = PH_PE;
            end
            PH_PE: begin
                step_a = {14'b0, sum_calc};
                step_b = dt_reg;
                step_phase = PH_A;
            end
            PH_A: begin
                step_a = integ_reg;
                step_b = {7'b0, e_reg};
                step_phase = PH_IE;
            end
            PH_IE: begin
                step_a = integ_clip;
                step_b = {4'b0, ktrans_reg};
                step_phase = PH_KI;
            end
            default: begin
                step_a = '0;
                step_b = '0;
                step_phase = PH_KI;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ktrans_reg <= KTRANS_RST;
            ve_reg     <= VE_RST;
            vp_reg     <= VP_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_KTRANS: ktrans_reg <= cfg_data;
                REG_VE:     ve_reg     <= cfg_data[16:0];
                REG_VP:     vp_reg     <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // sequencer, shared multiplier, divider and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_VPCA;
            prev_aif_reg  <= '0;
            prev_time_reg <= '0;
            integ_reg     <= '0;
            kep_reg       <= '0;
            out_valid_reg <= 1'b0;
            mcnt_reg      <= '0;
            dcnt_reg      <= '0;
        end else begin
            // result taken while no new one is loaded
            if (out_valid_reg && m_tready && (state_reg != S_OUT)) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        ca_reg    <= in_ca;
                        t_reg     <= in_t;
                        first_reg <= s_tuser;
                        dt_reg    <= in_dt;
                        sat_reg   <= 1'b0;
                        phase_reg <= PH_VPCA;
                        ma_reg    <= {40'b0, in_ca};
                        mb_reg    <= {7'b0, vp_reg};
                        mp_reg    <= '0;
                        mcnt_reg  <= '0;
                        drem_reg  <= '0;
                        dq_reg    <= {ktrans_reg, 16'b0};
                        dcnt_reg  <= '0;
                        if (s_tuser && !params_zero) begin
                            state_reg <= S_DIV;
                        end else begin
                            if (s_tuser) begin
                                kep_reg <= '0;
                            end
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_DIV: begin
                    drem_reg <= d_sub[16:0];
                    dq_reg   <= d_quot;
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (dcnt_reg == 6'd35) begin
                        kep_reg   <= kep_sat;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (mb_reg[0]) begin
                        mp_reg <= mp_reg + ma_reg;
                    end
                    ma_reg   <= ma_reg << 1;
                    mb_reg   <= mb_reg >> 1;
                    mcnt_reg <= mcnt_reg + 5'd1;
                    if (mcnt_reg == 5'd23) begin
                        state_reg <= S_STEP;
                    end
                end
                S_STEP: begin
                    // consume the finished product, launch the next one
                    ma_reg    <= {24'b0, step_a};
                    mb_reg    <= step_b;
                    mp_reg    <= '0;
                    mcnt_reg  <= '0;
                    phase_reg <= step_phase;
                    state_reg <= S_MUL;
                    unique case (phase_reg)
                        PH_VPCA: begin
                            vpca_reg <= mp_reg[40:0];
                            if (first_reg || params_zero) begin
                                integ_reg <= '0;
                                acc_reg   <= mp_reg;
                                state_reg <= S_OUT;
                            end
                        end
                        PH_Y: begin
                            idx_reg   <= y_idx;
                            n_reg     <= mp_reg[36:32];
                            ezero_reg <= mp_reg[56:32] >= 25'd17;
                        end
                        PH_INTERP: e_reg <= e_calc;
                        PH_A:      a_reg <= mp_reg[50:17];
                        PH_IE: begin
                            integ_reg <= integ_clip;
                            sat_reg   <= integ_ovf;
                        end
                        PH_KI: begin
                            acc_reg   <= mp_reg + {23'b0, vpca_reg};
                            state_reg <= S_OUT;
                        end
                        default: ;
                    endcase
                end
                S_OUT: begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= res_ovf ? 24'hFF_FFFF : res_sum[39:16];
                        out_sat_reg   <= sat_reg || res_ovf;
                        prev_aif_reg  <= ca_reg;
                        prev_time_reg <= t_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`include "extended_tofts_tissue_conc_defines.svh"

    // the sequencer leaves idle as soon as an item is taken
    `ETS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // a finished result waits while the output register is still held
    `ETS_ASSERT_NEXT(a_out_holds, out_wait, (state_reg == S_OUT) && m_tvalid)
    // the divider starts only with a nonzero divisor; ve_reg stays nonzero there unless a config write clears it
    `ETS_ASSERT_SAME(a_div_nonzero, (state_reg == S_DIV) && !cfg_valid, ve_reg != '0)

endmodule
